### src/brmr_pkg.sv
// brmr_pkg: shared types and codes for the broadcast ring with several readers
// no dependencies; imported by the reader lanes and the top level
package brmr_pkg;

  // command codes carried on cmd_i
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // result codes carried on status_o
  typedef enum logic [1:0] {
    ST_WRITTEN    = 2'd0,
    ST_DELIVERED  = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_BAD_READER = 2'd3
  } status_e;

  // top level sequencer
  typedef enum logic {
    FSM_IDLE,
    FSM_FETCH
  } fsm_e;

  // update request to the reader lanes
  typedef struct packed {
    logic bcast;  // a new entry was written, every reader gains one
    logic pop;    // the selected reader takes its oldest entry
  } lane_cmd_t;

endpackage

### src/brmr_entry_ram.sv
// brmr_entry_ram: entry store, one write port and one registered read port
// no dependencies; contents are not reset
module brmr_entry_ram #(
  parameter int RING_DEPTH = 16,
  parameter int ENTRY_BITS = 64,
  localparam int PtrW      = $clog2(RING_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [PtrW-1:0]       waddr_i,
  input  logic [ENTRY_BITS-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [PtrW-1:0]       raddr_i,
  output logic [ENTRY_BITS-1:0] rdata_o
);

  logic [ENTRY_BITS-1:0] mem_q [RING_DEPTH];
  logic [ENTRY_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/brmr_reader_lanes.sv
// brmr_reader_lanes: per-reader read position and unread count, one lane each
// depends on brmr_pkg for the update request type
module brmr_reader_lanes #(
  parameter int RING_DEPTH   = 16,
  parameter int READER_COUNT = 8,
  localparam int PtrW        = $clog2(RING_DEPTH),
  localparam int CntW        = $clog2(RING_DEPTH + 1),
  localparam int SelW        = (READER_COUNT > 1) ? $clog2(READER_COUNT) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brmr_pkg::lane_cmd_t cmd_i,
  input  logic [SelW-1:0]     sel_i,
  output logic [PtrW-1:0]     sel_pos_o,
  output logic                sel_empty_o
);
  import brmr_pkg::*;

  logic [PtrW-1:0] pos_q [READER_COUNT];
  logic [PtrW-1:0] pos_d [READER_COUNT];
  logic [CntW-1:0] cnt_q [READER_COUNT];
  logic [CntW-1:0] cnt_d [READER_COUNT];

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    n = (p == PtrW'(RING_DEPTH - 1)) ? '0 : p + PtrW'(1);
    return n;
  endfunction

  // write and read never come together, so each lane sees at most one update
  always_comb begin
    for (int i = 0; i < READER_COUNT; i++) begin
      pos_d[i] = pos_q[i];
      cnt_d[i] = cnt_q[i];
      if (cmd_i.bcast) begin
        if (cnt_q[i] == CntW'(RING_DEPTH)) begin
          pos_d[i] = ring_next(pos_q[i]);  // full lane drops its oldest entry
        end else begin
          cnt_d[i] = cnt_q[i] + CntW'(1);
        end
      end else if (cmd_i.pop && (sel_i == SelW'(i))) begin
        pos_d[i] = ring_next(pos_q[i]);
        cnt_d[i] = cnt_q[i] - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < READER_COUNT; i++) begin
        pos_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < READER_COUNT; i++) begin
        pos_q[i] <= pos_d[i];
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  assign sel_pos_o   = pos_q[sel_i];
  assign sel_empty_o = (cnt_q[sel_i] == '0);

  // a pop is only issued for a reader holding entries
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !sel_empty_o)
    else $error("pop issued to an empty reader");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.bcast && cmd_i.pop))
    else $error("broadcast and pop in the same cycle");

  for (genvar g = 0; g < READER_COUNT; g++) begin : g_chk
    a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q[g] <= CntW'(RING_DEPTH))
      else $error("unread count beyond ring depth");
  end

endmodule

### src/broadcast_ring_multi_reader.sv
// broadcast_ring_multi_reader: one writer, several readers over a shared ring
// write, empty and bad-reader results go straight into the output register on acceptance,
//   a delivered read passes through the entry memory read register, then the output register
// throughput: 1 beat per cycle for writes and refused reads while out_stall_i is low; a delivered
//   read stalls the input during FETCH, set by the registered read port of the entry memory
// reset clears write position, reader lanes and handshake; entry memory is not cleared
module broadcast_ring_multi_reader #(
  parameter int RING_DEPTH   = 16,
  parameter int READER_COUNT = 8,
  parameter int ENTRY_BITS   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [2:0]  reader_i,
  input  logic [63:0] entry_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [63:0] read_data_o
);
  import brmr_pkg::*;

  localparam int PtrW = $clog2(RING_DEPTH);
  localparam int SelW = (READER_COUNT > 1) ? $clog2(READER_COUNT) : 1;
  localparam int IdxW = (SelW > 3) ? SelW : 3;

  // sequencer state
  fsm_e state_q, state_d;

  // shared write position, wraps at the ring depth
  logic [PtrW-1:0] wpos_q, wpos_d;

  // output register, holds a result while the result side stalls
  logic                  out_valid_q;
  status_e               status_q;
  logic [63:0]           data_q;

  // decode of the incoming beat
  logic                  accept;
  logic                  is_write;
  logic                  reader_ok;
  logic [IdxW-1:0]       reader_ext;
  logic [SelW-1:0]       sel;
  logic [PtrW-1:0]       sel_pos;
  logic                  sel_empty;
  lane_cmd_t             lane_cmd;
  logic [ENTRY_BITS-1:0] ram_rdata;
  status_e               status_now;

  // a new beat is taken only when idle and the output register is free or draining
  assign in_stall_o = !((state_q == FSM_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept     = in_valid_i && !in_stall_o;
  assign is_write   = (cmd_i == CMD_WRITE);

  // reader numbers beyond the configured count are refused before any lane lookup
  assign reader_ok  = (int'(reader_i) < READER_COUNT);
  assign reader_ext = IdxW'(reader_i);
  assign sel        = reader_ext[SelW-1:0];

  brmr_reader_lanes #(
    .RING_DEPTH  (RING_DEPTH),
    .READER_COUNT(READER_COUNT)
  ) u_lanes (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (lane_cmd),
    .sel_i      (sel),
    .sel_pos_o  (sel_pos),
    .sel_empty_o(sel_empty)
  );

  // the store is written on the accept edge; a read of the same slot can only
  // be issued on a later beat, so no forwarding is needed
  brmr_entry_ram #(
    .RING_DEPTH(RING_DEPTH),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (lane_cmd.bcast),
    .waddr_i(wpos_q),
    .wdata_i(entry_data_i[ENTRY_BITS-1:0]),
    .re_i   (lane_cmd.pop),
    .raddr_i(sel_pos),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (lane_cmd.pop) begin
          state_d = FSM_FETCH;
        end
      end
      FSM_FETCH: begin
        state_d = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // outputs of the sequencer: lane updates, memory strobes, immediate status
  always_comb begin
    lane_cmd.bcast = 1'b0;
    lane_cmd.pop   = 1'b0;
    status_now     = ST_WRITTEN;
    case (state_q)
      FSM_IDLE: begin
        if (is_write) begin
          lane_cmd.bcast = accept;
          status_now     = ST_WRITTEN;
        end else if (!reader_ok) begin
          status_now     = ST_BAD_READER;
        end else if (sel_empty) begin
          status_now     = ST_EMPTY;
        end else begin
          lane_cmd.pop   = accept;
          status_now     = ST_DELIVERED;
        end
      end
      FSM_FETCH: begin
        status_now = ST_DELIVERED;
      end
      default: begin
        status_now = ST_WRITTEN;
      end
    endcase
  end

  assign wpos_d = !lane_cmd.bcast               ? wpos_q :
                  (wpos_q == PtrW'(RING_DEPTH - 1)) ? '0 : wpos_q + PtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      wpos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wpos_q  <= wpos_d;
      if ((accept && !lane_cmd.pop) || (state_q == FSM_FETCH)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload; zero data unless an entry is delivered
  always_ff @(posedge clk_i) begin
    if (state_q == FSM_FETCH) begin
      status_q <= ST_DELIVERED;
      data_q   <= 64'(ram_rdata);
    end else if (accept && !lane_cmd.pop) begin
      status_q <= status_now;
      data_q   <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign read_data_o = data_q;

  // the memory read always lands in an empty output register
  a_fetch_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_FETCH) |-> !out_valid_q)
    else $error("output register busy during fetch");

  a_fetch_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_FETCH) |=> (out_valid_o && (status_o == ST_DELIVERED)))
    else $error("fetch did not deliver an entry");

  a_fetch_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_FETCH) |-> in_stall_o)
    else $error("input taken while a fetch is pending");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DELIVERED)) |-> (read_data_o == '0))
    else $error("non-zero data on a refused or write result");

endmodule

### dv/ring_result_checker.sv
`timescale 1ns / 1ps
// ring_result_checker: watches both channels of the broadcast ring and checks every result beat
// depends on brmr_pkg for the command and status codes

module ring_result_checker #(
  parameter int RING_DEPTH   = 16,
  parameter int READER_COUNT = 8,
  parameter int ENTRY_BITS   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        cmd_i,
  input  logic [2:0]  reader_i,
  input  logic [63:0] entry_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [63:0] read_data_i,
  output int          mismatches_o,
  output int          awaiting_o
);
  import brmr_pkg::*;

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [63:0] ENTRY_MASK = {64{1'b1}} >> (64 - ENTRY_BITS);

  typedef struct packed {
    status_e     status;
    logic [63:0] data;
  } outcome_t;

  // shadow of the ring and of every reader lane
  logic [63:0]   slots      [RING_DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail       [READER_COUNT];
  logic [CW-1:0] unread     [READER_COUNT];

  outcome_t awaited_outcomes[$];
  int       fails;

  function automatic logic [PW-1:0] step_slot(input logic [PW-1:0] pos);
    return (pos == PW'(RING_DEPTH - 1)) ? '0 : pos + 1'b1;
  endfunction

  // applies one accepted beat to the shadow state and returns its result
  function automatic outcome_t access_outcome(input logic op, input logic [2:0] who,
                                              input logic [63:0] word);
    outcome_t res;
    res.status = ST_WRITTEN;
    res.data   = '0;
    if (op == CMD_WRITE) begin
      slots[head] = word & ENTRY_MASK;
      head = step_slot(head);
      for (int r = 0; r < READER_COUNT; r++) begin
        // a full reader drops its oldest entry
        if (unread[r] >= CW'(RING_DEPTH)) tail[r] = step_slot(tail[r]);
        else unread[r] = unread[r] + 1'b1;
      end
    end else if (int'(who) >= READER_COUNT) begin
      res.status = ST_BAD_READER;
    end else if (unread[who] == '0) begin
      res.status = ST_EMPTY;
    end else begin
      res.status  = ST_DELIVERED;
      res.data    = slots[tail[who]] & ENTRY_MASK;
      tail[who]   = step_slot(tail[who]);
      unread[who] = unread[who] - 1'b1;
    end
    return res;
  endfunction

  task automatic log_failure(input bit stray, input outcome_t want);
    fails++;
    if (fails <= 10) begin
      if (stray)
        $display("%0t: result beat with nothing awaited: status %0d data %h",
                 $time, status_i, read_data_i);
      else
        $display("%0t: result mismatch: expected status %0d data %h, got status %0d data %h",
                 $time, want.status, want.data, status_i, read_data_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      head = '0;
      for (int r = 0; r < READER_COUNT; r++) begin
        tail[r]   = '0;
        unread[r] = '0;
      end
      awaited_outcomes.delete();
      fails = 0;
      mismatches_o <= 0;
      awaiting_o   <= 0;
    end else begin
      // results first: a beat accepted now cannot answer at this same edge
      if (out_valid_i && !out_stall_i) begin
        if (awaited_outcomes.size() == 0) begin
          want = '0;
          log_failure(1'b1, want);
        end else begin
          want = awaited_outcomes.pop_front();
          if (status_i !== want.status || read_data_i !== want.data) log_failure(1'b0, want);
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_outcomes.push_back(access_outcome(cmd_i, reader_i, entry_data_i));
      mismatches_o <= fails;
      awaiting_o   <= awaited_outcomes.size();
    end
  end

endmodule

### dv/broadcast_ring_multi_reader_test.sv
`timescale 1ns / 1ps
// broadcast_ring_multi_reader_test: stimulus and verdict for the broadcast ring
// depends on brmr_pkg, broadcast_ring_multi_reader and ring_result_checker

module broadcast_ring_multi_reader_test;
  import brmr_pkg::*;

  localparam int RANDOM_BEATS = 1200;
  localparam int HOLD_CYCLES  = 150;   // long result hold-off, well past the ring's buffering
  localparam int HOLD_START   = 300;
  localparam int HOLD_BEATS   = 60;
  localparam int DRAIN_AT     = 650;
  localparam int CALM_BEATS   = 200;   // tail of the run with no idling on either side

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [2:0]  reader;
  logic [63:0] entry_data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [63:0] read_data;

  int mismatches;
  int awaiting;
  int hold_asked;   // bumped by the sender to request one long hold-off
  bit calm;         // no idling on either side once set
  bit steady;       // sender offers back to back

  broadcast_ring_multi_reader dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .reader_i     (reader),
    .entry_data_i (entry_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .read_data_o  (read_data)
  );

  ring_result_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .reader_i     (reader),
    .entry_data_i (entry_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .status_i     (status),
    .read_data_i  (read_data),
    .mismatches_o (mismatches),
    .awaiting_o   (awaiting)
  );

  // free-running clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling: far beyond the slowest correct run with every gap and stall at its longest
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off counted here on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one beat, maybe after an idle burst, and wait for its handshake;
  // valid stays high into the next beat unless a gap is taken
  task automatic offer_beat(input logic op, input logic [2:0] who, input logic [63:0] word);
    if (!calm && !steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    reader     <= who;
    entry_data <= word;
    do @(posedge clk); while (in_stall);
  endtask

  // sender goes quiet until every awaited result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  initial begin
    int write_pct;
    logic op;
    in_valid   <= 1'b0;
    cmd        <= CMD_WRITE;
    reader     <= '0;
    entry_data <= '0;
    hold_asked <= 0;
    calm       <= 1'b0;
    steady     = 1'b0;
    rst_n      <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty readers straight after reset, lowest and highest reader number
    offer_beat(CMD_READ, 3'd0, '0);
    offer_beat(CMD_READ, 3'd7, '0);
    // field extremes and alternating patterns on the data
    offer_beat(CMD_WRITE, 3'd7, 64'h0);
    offer_beat(CMD_WRITE, 3'd0, {64{1'b1}});
    offer_beat(CMD_WRITE, 3'd5, {32{2'b10}});
    offer_beat(CMD_WRITE, 3'd2, {32{2'b01}});
    offer_beat(CMD_READ, 3'd0, '0);
    offer_beat(CMD_READ, 3'd0, '0);
    // reader 0 ends up exactly full, the rest overflow and drop their two oldest
    for (int i = 0; i < 14; i++) offer_beat(CMD_WRITE, 3'(i), {$urandom, $urandom});
    offer_beat(CMD_READ, 3'd7, '0);
    // one more write overflows reader 0 as well
    offer_beat(CMD_WRITE, 3'd3, {$urandom, $urandom});
    offer_beat(CMD_READ, 3'd0, '0);

    // random part: phases lean on writes, reads or an even mix,
    // so readers swing between empty, part full and saturated
    write_pct = 50;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       write_pct = 8;
          1:       write_pct = 50;
          default: write_pct = 85;
        endcase
      end
      // results held back while beats keep coming, so the block backs up
      if (n == HOLD_START) begin
        hold_asked <= hold_asked + 1;
        steady = 1'b1;
      end
      if (n == HOLD_START + HOLD_BEATS) steady = 1'b0;
      if (n == DRAIN_AT) drain_results();
      if (n == RANDOM_BEATS - CALM_BEATS) calm <= 1'b1;
      op = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_READ;
      offer_beat(op, 3'($urandom_range(0, 7)), {$urandom, $urandom});
    end

    // everything back, then an idle wait to catch any stray result beat
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
